>>> rtl/core/bvol_pkg.sv
// Shared types and constants for the vertex bounding volume block.
`default_nettype none

package bvol_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int AXES        = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int SQ_WIDTH   = 2 * COORD_WIDTH;
  localparam int ROOT_WIDTH = COORD_WIDTH + 1;
  localparam int RAD_WIDTH  = 2 * ROOT_WIDTH;
  localparam int REM_WIDTH  = ROOT_WIDTH + 3;
  localparam int ITER_CNT_W = $clog2(ROOT_WIDTH);
  localparam int AX_CNT_W   = $clog2(AXES + 1);
  localparam int AX_IDX_W   = $clog2(AXES);
  localparam int Q_PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0]     coord_t;
  typedef logic [AXES-1:0][COORD_WIDTH-1:0]  coord_vec_t;
  typedef logic [ROOT_WIDTH-1:0]             root_t;
  typedef logic [RAD_WIDTH-1:0]              rad_t;

  localparam coord_t COORD_MOST_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MOST_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // One finished box handed from the accumulator to the result side.
  typedef struct packed {
    coord_vec_t lo;
    coord_vec_t hi;
  } box_t;

  typedef struct packed {
    logic start;
    rad_t rad;
  } sq_req_t;

  typedef struct packed {
    logic  done;
    root_t root;
  } sq_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_ROOT_GO,
    BK_ROOT_WAIT,
    BK_OUT
  } bk_state_t;

endpackage

`default_nettype wire

>>> rtl/core/bvol_if.sv
// Valid/ready channel interfaces for vertex words and result words.
`default_nettype none

interface bvol_vtx_if;
  import bvol_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;
  logic   last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

interface bvol_res_if;
  import bvol_pkg::*;

  logic   valid;
  logic   ready;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;
  root_t  diagonal_length;

  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, center_x, center_y, center_z, diagonal_length, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, center_x, center_y, center_z, diagonal_length, output ready);
endinterface

`default_nettype wire

>>> rtl/core/vertex_bounding_volume.sv
// Top level of the vertex bounding volume block.
// Vertex words are taken one per cycle; the running minimum and maximum on each
// axis are updated in the cycle a word is accepted, and the word marked
// last_vertex closes the set and queues its box (two boxes can wait). Each
// closed set produces one result word after its box leaves the queue: the box
// is loaded, the three squared extents are summed through the single shared
// multiplier, and the bit-serial square root gives the diagonal. Vertex
// words of a new set keep flowing while results are computed; only a closing
// vertex waits, and only when both queue slots are full.
`default_nettype none

module vertex_bounding_volume (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bvol_vtx_if.sink   in_ch,
  bvol_res_if.source out_ch
);
  import bvol_pkg::*;

  logic    push, q_full, q_valid, q_pop;
  box_t    push_data, q_data;
  sq_req_t sq_req;
  sq_rsp_t sq_rsp;

  bvol_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bvol_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  bvol_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (sq_req),
    .rsp_o (sq_rsp)
  );

  bvol_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .sq_req_o  (sq_req),
    .sq_rsp_i  (sq_rsp),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/core/bvol_front.sv
// Front end: accepts vertex words and keeps the running per-axis box.
`default_nettype none

module bvol_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  bvol_vtx_if.sink            in_ch,
  input  wire logic           q_full_i,
  output logic                push_o,
  output bvol_pkg::box_t      push_data_o
);
  import bvol_pkg::*;

  coord_vec_t min_r, min_nxt;
  coord_vec_t max_r, max_nxt;
  coord_vec_t vtx;
  logic       accept;

  assign vtx[0] = in_ch.vertex_x;
  assign vtx[1] = in_ch.vertex_y;
  assign vtx[2] = in_ch.vertex_z;

  // Only the closing vertex needs a queue slot, so the others always pass.
  assign in_ch.ready = !q_full_i || !in_ch.last_vertex;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      min_nxt[a] = ($signed(vtx[a]) < $signed(min_r[a])) ? vtx[a] : min_r[a];
      max_nxt[a] = ($signed(vtx[a]) > $signed(max_r[a])) ? vtx[a] : max_r[a];
    end
  end

  assign push_o         = accept && in_ch.last_vertex;
  assign push_data_o.lo = min_nxt;
  assign push_data_o.hi = max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push_o) begin
      for (int a = 0; a < AXES; a++) begin
        min_r[a] <= COORD_MOST_POS;
        max_r[a] <= COORD_MOST_NEG;
      end
    end else if (accept) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bvol_fifo.sv
// Short queue of finished boxes between the front and back ends.
`default_nettype none

module bvol_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  wire bvol_pkg::box_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bvol_pkg::box_t      data_o
);
  import bvol_pkg::*;

  box_t                 mem_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic                 do_push, do_pop;

  assign full_o  = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_r != '0);
  assign data_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data_i;
  end

endmodule

`default_nettype wire

>>> rtl/core/bvol_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none

module bvol_isqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bvol_pkg::sq_req_t req_i,
  output bvol_pkg::sq_rsp_t      rsp_o
);
  import bvol_pkg::*;

  rad_t                    rad_r;
  logic [REM_WIDTH-1:0]    rem_r, rem_sh, trial, rem_nxt;
  root_t                   root_r, root_nxt;
  logic [ITER_CNT_W-1:0]   cnt_r;
  logic                    busy_r, done_r;

  // Restoring method: bring down two radicand bits, try appending a one.
  always_comb begin
    rem_sh = {rem_r[REM_WIDTH-3:0], rad_r[RAD_WIDTH-1 -: 2]};
    trial  = REM_WIDTH'({root_r, 2'b01});
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[ROOT_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[ROOT_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ITER_CNT_W'(ROOT_WIDTH - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rad_r  <= req_i.rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_WIDTH-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.root = root_r;

endmodule

`default_nettype wire

>>> rtl/core/bvol_back.sv
// Back end: centre, squared extents, diagonal and the result register.
`default_nettype none

module bvol_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid_i,
  input  wire bvol_pkg::box_t    q_data_i,
  output logic                   q_pop_o,
  output bvol_pkg::sq_req_t      sq_req_o,
  input  wire bvol_pkg::sq_rsp_t sq_rsp_i,
  bvol_res_if.source             out_ch
);
  import bvol_pkg::*;

  bk_state_t               state_r, state_nxt;
  logic [AX_CNT_W-1:0]     cnt_r, cnt_nxt;
  coord_vec_t              lo_r, hi_r, ctr_r;
  logic [COORD_WIDTH-1:0]  ext_r [AXES];
  logic [COORD_WIDTH-1:0]  ext_sel;
  logic [SQ_WIDTH-1:0]     prod_r;
  rad_t                    sum_r;
  root_t                   diag_r;
  logic                    load;
  logic                    accum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    load           = 1'b0;
    accum          = 1'b0;
    sq_req_o.start = 1'b0;
    sq_req_o.rad   = sum_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid_i) begin
          load      = 1'b1;
          cnt_nxt   = '0;
          state_nxt = BK_SQUARE;
        end
      end
      BK_SQUARE: begin
        // The product register holds the square for the axis before the current count.
        accum   = (cnt_r != '0);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == AX_CNT_W'(AXES)) state_nxt = BK_ROOT_GO;
      end
      BK_ROOT_GO: begin
        sq_req_o.start = 1'b1;
        state_nxt      = BK_ROOT_WAIT;
      end
      BK_ROOT_WAIT: begin
        if (sq_rsp_i.done) state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_ch.ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign q_pop_o      = load;
  assign ext_sel      = (cnt_r < AX_CNT_W'(AXES)) ? ext_r[cnt_r[AX_IDX_W-1:0]] : '0;

  always_ff @(posedge clk) begin
    if (load) begin
      lo_r <= q_data_i.lo;
      hi_r <= q_data_i.hi;
      for (int a = 0; a < AXES; a++) begin
        // Sum and difference at one extra bit; the extent is never negative.
        ext_r[a] <= COORD_WIDTH'({q_data_i.hi[a][COORD_WIDTH-1], q_data_i.hi[a]}
                                - {q_data_i.lo[a][COORD_WIDTH-1], q_data_i.lo[a]});
        ctr_r[a] <= COORD_WIDTH'(({q_data_i.hi[a][COORD_WIDTH-1], q_data_i.hi[a]}
                                 + {q_data_i.lo[a][COORD_WIDTH-1], q_data_i.lo[a]}) >> 1);
      end
    end
    prod_r <= SQ_WIDTH'(ext_sel) * SQ_WIDTH'(ext_sel);
    if (load)       sum_r <= '0;
    else if (accum) sum_r <= sum_r + RAD_WIDTH'(prod_r);
    if (sq_rsp_i.done) diag_r <= sq_rsp_i.root;
  end

  assign out_ch.valid           = (state_r == BK_OUT);
  assign out_ch.box_min_x       = lo_r[0];
  assign out_ch.box_min_y       = lo_r[1];
  assign out_ch.box_min_z       = lo_r[2];
  assign out_ch.box_max_x       = hi_r[0];
  assign out_ch.box_max_y       = hi_r[1];
  assign out_ch.box_max_z       = hi_r[2];
  assign out_ch.center_x        = ctr_r[0];
  assign out_ch.center_y        = ctr_r[1];
  assign out_ch.center_z        = ctr_r[2];
  assign out_ch.diagonal_length = diag_r;

endmodule

`default_nettype wire

>>> rtl/core/bvol_checker.sv
// Port-level checks for the vertex bounding volume block, bound to the top level.
`default_nettype none

module bvol_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire bvol_pkg::coord_t out_min_x,
  input wire bvol_pkg::coord_t out_min_y,
  input wire bvol_pkg::coord_t out_max_x,
  input wire bvol_pkg::coord_t out_max_y,
  input wire bvol_pkg::coord_t out_ctr_x,
  input wire bvol_pkg::root_t  out_diag
);
  import bvol_pkg::*;

  logic [COORD_WIDTH:0] ext_x;

  assign ext_x = {out_max_x[COORD_WIDTH-1], out_max_x} - {out_min_x[COORD_WIDTH-1], out_min_x};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_diag) && $stable(out_min_x))
    else $error("result word changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_x <= out_max_x && out_min_y <= out_max_y)
    else $error("box minimum above maximum");

  a_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_x <= out_ctr_x && out_ctr_x <= out_max_x)
    else $error("center outside the box");

  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_diag} >= {1'b0, ext_x}))
    else $error("diagonal shorter than x extent");

endmodule

bind vertex_bounding_volume bvol_checker u_bvol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_min_x (out_ch.box_min_x),
  .out_min_y (out_ch.box_min_y),
  .out_max_x (out_ch.box_max_x),
  .out_max_y (out_ch.box_max_y),
  .out_ctr_x (out_ch.center_x),
  .out_diag  (out_ch.diagonal_length)
);

`default_nettype wire

>>> bench/tb_vertex_bounding_volume.sv
// Self-checking testbench for vertex_bounding_volume: random vertex sets with bursty input and output stalls.
`default_nettype none

module tb_vertex_bounding_volume;
  timeunit 1ns;
  timeprecision 1ps;

  import bvol_pkg::*;

  localparam int WORD_TARGET  = 1750;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int END_PAUSE    = 80;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int RX_PHASE     = 300;

  typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;
  typedef enum int {STYLE_FULL, STYLE_CLUSTER, STYLE_EXTREME, STYLE_SMALL} set_style_t;

  typedef struct packed {
    logic   drain;
    logic   last;
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_word_t;

  typedef struct packed {
    coord_vec_t lo;
    coord_vec_t hi;
    coord_vec_t mid;
    root_t      diag;
  } box_summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bvol_vtx_if vtx_ch ();
  bvol_res_if res_ch ();

  vertex_bounding_volume dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (vtx_ch),
    .out_ch (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vtx_word_t    pending_words [$];
  box_summary_t box_expect_q [$];
  coord_t       run_lo [AXES];
  coord_t       run_hi [AXES];

  int  words_queued = 0;
  int  words_in     = 0;
  int  sets_closed  = 0;
  int  results_seen = 0;
  int  mismatches   = 0;
  int  cycle_count  = 0;
  int  gap_left     = 0;
  int  burst_left   = 1;
  int  hold_left    = 0;
  bit  hold_used    = 1'b0;
  logic word_taken  = 1'b0;
  vtx_word_t next_word;
  string axis_letters = "xyz";

  task automatic clear_bounds();
    for (int a = 0; a < AXES; a++) begin
      run_lo[a] = COORD_MOST_POS;
      run_hi[a] = COORD_MOST_NEG;
    end
  endtask

  function automatic root_t floor_sqrt(rad_t n);
    root_t r;
    root_t cand;
    rad_t  sq;
    r = '0;
    for (int b = ROOT_WIDTH - 1; b >= 0; b--) begin
      cand = r | (root_t'(1) << b);
      sq = rad_t'(cand) * rad_t'(cand);
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  // Folds one accepted vertex word into the running box; a closing word yields
  // the expected summary and starts a fresh set.
  task automatic fold_vertex(coord_t x, coord_t y, coord_t z, logic last);
    coord_t       v [AXES];
    box_summary_t s;
    root_t        ext;
    root_t        mid_sum;
    rad_t         acc;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    for (int a = 0; a < AXES; a++) begin
      if (v[a] < run_lo[a]) run_lo[a] = v[a];
      if (v[a] > run_hi[a]) run_hi[a] = v[a];
    end
    if (last) begin
      acc = '0;
      for (int a = 0; a < AXES; a++) begin
        s.lo[a] = run_lo[a];
        s.hi[a] = run_hi[a];
        // One extra bit keeps the sum exact; dropping its low bit floors it.
        mid_sum = {run_lo[a][COORD_WIDTH-1], run_lo[a]} + {run_hi[a][COORD_WIDTH-1], run_hi[a]};
        s.mid[a] = mid_sum[ROOT_WIDTH-1:1];
        ext = {run_hi[a][COORD_WIDTH-1], run_hi[a]} - {run_lo[a][COORD_WIDTH-1], run_lo[a]};
        acc = acc + rad_t'(ext) * rad_t'(ext);
      end
      s.diag = floor_sqrt(acc);
      box_expect_q.push_back(s);
      sets_closed++;
      clear_bounds();
    end
  endtask

  task automatic check_field(string name, root_t want, root_t got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_word(coord_t x, coord_t y, coord_t z, logic last);
    vtx_word_t w;
    w.drain = 1'b0;
    w.last  = last;
    w.x     = x;
    w.y     = y;
    w.z     = z;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_drain();
    vtx_word_t w;
    w = '0;
    w.drain = 1'b1;
    pending_words.push_back(w);
  endtask

  function automatic coord_t rand_coord(set_style_t style, coord_t anchor);
    case (style)
      STYLE_FULL:    return coord_t'($urandom);
      STYLE_CLUSTER: return anchor + coord_t'($urandom_range(0, 4096)) - coord_t'(2048);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return COORD_MOST_NEG;
          1:       return COORD_MOST_POS;
          2:       return coord_t'(0);
          3:       return coord_t'(-1);
          4:       return coord_t'(1);
          default: return coord_t'($urandom);
        endcase
      end
      default:       return coord_t'($urandom_range(0, 131072)) - coord_t'(65536);
    endcase
  endfunction

  // Input side: bursts of words separated by random gaps; a drain marker
  // parks the line until every pending result word has come back.
  always @(negedge clk) begin
    if (!rst_n) begin
      vtx_ch.valid <= 1'b0;
    end else if (!vtx_ch.valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        vtx_ch.valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        vtx_ch.valid <= 1'b0;
      end else if (pending_words[0].drain) begin
        if (box_expect_q.size() == 0) void'(pending_words.pop_front());
        vtx_ch.valid <= 1'b0;
      end else begin
        next_word = pending_words.pop_front();
        vtx_ch.valid       <= 1'b1;
        vtx_ch.vertex_x    <= next_word.x;
        vtx_ch.vertex_y    <= next_word.y;
        vtx_ch.vertex_z    <= next_word.z;
        vtx_ch.last_vertex <= next_word.last;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 4);
            default:    gap_left = $urandom_range(5, 25);
          endcase
        end
      end
    end
  end

  // Output side: the stall pattern rotates through several modes, and one long
  // hold-off lets the block back up into its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (!hold_used && results_seen >= HOLD_AFTER) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else begin
      case (rx_mode_t'((cycle_count / RX_PHASE) % 4))
        RX_ALWAYS: res_ch.ready <= 1'b1;
        RX_LIGHT:  res_ch.ready <= ($urandom_range(0, 9) < 8);
        RX_HEAVY:  res_ch.ready <= ($urandom_range(0, 9) < 3);
        default:   res_ch.ready <= ((cycle_count % 11) < 4);
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    box_summary_t want;
    box_summary_t got;
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= vtx_ch.valid && vtx_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (box_expect_q.size() == 0) begin
          $error("result word arrived with no closed set pending");
          mismatches++;
        end else begin
          want = box_expect_q.pop_front();
          got.lo   = {res_ch.box_min_z, res_ch.box_min_y, res_ch.box_min_x};
          got.hi   = {res_ch.box_max_z, res_ch.box_max_y, res_ch.box_max_x};
          got.mid  = {res_ch.center_z, res_ch.center_y, res_ch.center_x};
          got.diag = res_ch.diagonal_length;
          for (int a = 0; a < AXES; a++) begin
            check_field({"box_min_", axis_letters.substr(a, a)}, {1'b0, want.lo[a]},
                        {1'b0, got.lo[a]});
            check_field({"box_max_", axis_letters.substr(a, a)}, {1'b0, want.hi[a]},
                        {1'b0, got.hi[a]});
            check_field({"center_", axis_letters.substr(a, a)}, {1'b0, want.mid[a]},
                        {1'b0, got.mid[a]});
          end
          check_field("diagonal_length", want.diag, got.diag);
        end
      end
      if (vtx_ch.valid && vtx_ch.ready) begin
        words_in++;
        fold_vertex(vtx_ch.vertex_x, vtx_ch.vertex_y, vtx_ch.vertex_z, vtx_ch.last_vertex);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d result words outstanding.",
               cycle_count, box_expect_q.size());
      $display("** vertex_bounding_volume: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    set_style_t style;
    coord_t     anchor;
    int         len;
    bit         mid_drain;
    vtx_ch.valid       = 1'b0;
    vtx_ch.vertex_x    = '0;
    vtx_ch.vertex_y    = '0;
    vtx_ch.vertex_z    = '0;
    vtx_ch.last_vertex = 1'b0;
    res_ch.ready       = 1'b0;
    mid_drain          = 1'b0;
    clear_bounds();

    // Single-vertex sets at zero and at both ends of the range.
    queue_word(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
    queue_word(COORD_MOST_POS, COORD_MOST_POS, COORD_MOST_POS, 1'b1);
    queue_word(COORD_MOST_NEG, COORD_MOST_NEG, COORD_MOST_NEG, 1'b1);
    // Full-range box on every axis gives the largest diagonal and odd centers.
    queue_word(COORD_MOST_NEG, COORD_MOST_POS, COORD_MOST_NEG, 1'b0);
    queue_word(COORD_MOST_POS, COORD_MOST_NEG, COORD_MOST_POS, 1'b1);
    // A single vertex right after a wide set shows the bounds were cleared.
    queue_word(coord_t'(5), coord_t'(-7), coord_t'(9), 1'b1);
    // Small mixed-sign set with odd center sums of both signs and an even negative one.
    queue_word(coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b0);
    queue_word(coord_t'(1), coord_t'(2), coord_t'(3), 1'b0);
    queue_word(coord_t'(-3), coord_t'(0), coord_t'(-6), 1'b1);
    // Spread on one axis only.
    queue_word(coord_t'(32'h0001_0000), coord_t'(100), coord_t'(-100), 1'b0);
    queue_word(coord_t'(32'h7FFF_0000), coord_t'(100), coord_t'(-100), 1'b1);
    // Repeated identical vertices give a zero-size box.
    queue_word(coord_t'(32'hDEAD_BEEF), coord_t'(32'h1234_5678), coord_t'(32'hA5A5_5A5A), 1'b0);
    queue_word(coord_t'(32'hDEAD_BEEF), coord_t'(32'h1234_5678), coord_t'(32'hA5A5_5A5A), 1'b0);
    queue_word(coord_t'(32'hDEAD_BEEF), coord_t'(32'h1234_5678), coord_t'(32'hA5A5_5A5A), 1'b1);
    queue_drain();

    while (words_queued < WORD_TARGET) begin
      style  = set_style_t'($urandom_range(0, 3));
      anchor = coord_t'($urandom);
      case ($urandom_range(0, 19))
        0:                        len = $urandom_range(21, 60);
        1, 2, 3, 4, 5:            len = $urandom_range(7, 20);
        default:                  len = $urandom_range(1, 6);
      endcase
      for (int i = 0; i < len; i++) begin
        queue_word(rand_coord(style, anchor), rand_coord(style, anchor),
                   rand_coord(style, anchor), i == len - 1);
      end
      if (!mid_drain && words_queued >= WORD_TARGET / 2) begin
        mid_drain = 1'b1;
        queue_drain();
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || vtx_ch.valid || box_expect_q.size() != 0)
      @(negedge clk);
    repeat (END_PAUSE) @(negedge clk);

    $display("Covered %0d vertex words in %0d sets; %0d result words checked under bursty input,",
             words_in, sets_closed, results_seen);
    $display("rotating output stalls and one long output hold; %0d mismatches.", mismatches);
    if (mismatches == 0 && box_expect_q.size() == 0) begin
      $display("** vertex_bounding_volume: PASSED **");
    end else begin
      $display("** vertex_bounding_volume: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
